### rtl/yrc_pkg.sv
// Package for the YUYV to RGB converter: payload types, coefficients and widths.
package yrc_pkg;

    // Width of the fixed-point accumulator (signed, 16 fraction bits)
    localparam int ACC_W     = 26;
    localparam int FRAC_BITS = 16;
    localparam int CHAN_W    = 8;

    // Register stages from input transfer to result
    localparam int STAGES    = 3;

    // Colour coefficients, value * 65536, rounded to nearest
    localparam logic signed [ACC_W-1:0] COEF_RV = ACC_W'(89831);
    localparam logic signed [ACC_W-1:0] COEF_GV = ACC_W'(45744);
    localparam logic signed [ACC_W-1:0] COEF_GU = ACC_W'(22127);
    localparam logic signed [ACC_W-1:0] COEF_BU = ACC_W'(113538);

    // Output scaling: (x * SCALE_MUL) >> CHAN_W
    localparam logic [CHAN_W-1:0] SCALE_MUL = 8'd220;
    localparam logic [CHAN_W-1:0] CHAN_MAX  = 8'd255;

    // One packed YUYV macropixel
    typedef struct packed {
        logic [7:0] luma_first;
        logic [7:0] chroma_blue;
        logic [7:0] luma_second;
        logic [7:0] chroma_red;
        logic       frame_end_in;
    } yuyv_in_t;

    // Two converted RGB pixels
    typedef struct packed {
        logic [7:0] red_first;
        logic [7:0] green_first;
        logic [7:0] blue_first;
        logic [7:0] red_second;
        logic [7:0] green_second;
        logic [7:0] blue_second;
        logic       frame_end_out;
    } rgb_out_t;

    // Chroma products shared by both pixels of a macropixel
    typedef struct packed {
        logic signed [ACC_W-1:0] rv;
        logic signed [ACC_W-1:0] gv;
        logic signed [ACC_W-1:0] gu;
        logic signed [ACC_W-1:0] bu;
    } chroma_prod_t;

    // One scaled RGB pixel
    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_rgb_t;

endpackage

### rtl/yrc_pixel.sv
// One pixel of the converter: luma plus chroma sums, then clamp and scale.
module yrc_pixel (
    input  logic                 clk,
    input  logic [7:0]           luma,
    input  yrc_pkg::chroma_prod_t prod,
    output yrc_pkg::pixel_rgb_t  rgb
);
    import yrc_pkg::*;

    logic signed [ACC_W-1:0] base;
    logic signed [ACC_W-1:0] sum_r_next, sum_g_next, sum_b_next;
    logic signed [ACC_W-1:0] sum_r_reg, sum_g_reg, sum_b_reg;
    pixel_rgb_t              rgb_next, rgb_reg;

    // Clamp the floored sum to 0..255, then scale to 0..219
    function automatic logic [CHAN_W-1:0] clamp_scale(input logic signed [ACC_W-1:0] acc);
        logic [ACC_W-FRAC_BITS-1:0] whole;
        logic [CHAN_W-1:0]          chan;
        logic [2*CHAN_W-1:0]        scaled;
        whole = acc[ACC_W-1:FRAC_BITS];
        if (acc[ACC_W-1])
            chan = '0;
        else if (whole[ACC_W-FRAC_BITS-1:CHAN_W] != '0)
            chan = CHAN_MAX;
        else
            chan = whole[CHAN_W-1:0];
        scaled = {{CHAN_W{1'b0}}, chan} * {{CHAN_W{1'b0}}, SCALE_MUL};
        return scaled[2*CHAN_W-1:CHAN_W];
    endfunction

    // Stage 2: channel sums
    assign base = $signed({{(ACC_W-FRAC_BITS-8){1'b0}}, luma, {FRAC_BITS{1'b0}}});

    always_comb
    begin
        sum_r_next = base + prod.rv;
        sum_g_next = base - prod.gv - prod.gu;
        sum_b_next = base + prod.bu;
    end

    always_ff @(posedge clk)
    begin
        sum_r_reg <= sum_r_next;
        sum_g_reg <= sum_g_next;
        sum_b_reg <= sum_b_next;
    end

    // Stage 3: clamp and scale into the output register
    always_comb
    begin
        rgb_next.red   = clamp_scale(sum_r_reg);
        rgb_next.green = clamp_scale(sum_g_reg);
        rgb_next.blue  = clamp_scale(sum_b_reg);
    end

    always_ff @(posedge clk)
    begin
        rgb_reg <= rgb_next;
    end

    assign rgb = rgb_reg;

endmodule

### rtl/yuyv_to_rgb_converter_core.sv
// Top level of the YUYV 4:2:2 to scaled RGB888 converter.
//
// Usage:
//   Input: drive a macropixel (Y0, U, Y1, V and a last-of-frame mark) on
//   macropixel and raise start; the transfer happens at the clock edge where
//   start is high and busy is low. busy is always low, so a new macropixel
//   may be presented in every cycle.
//   Output: each macropixel yields one result of two RGB pixels on rgb_pair,
//   marked by done for exactly one cycle. The receiver cannot stall; results
//   must be taken as they come.
//   Pipeline: three register stages lie between the input transfer and done
//   (chroma products, channel sums, clamp and scale).
//   Throughput: one macropixel per cycle, set by the three-stage pipeline
//   with one multiplier per coefficient and one scaler per channel of each pixel.
//   Reset: rst_n clears the valid bits of the pipeline; items in flight are
//   dropped and no done follows until new input arrives. The arithmetic
//   registers are not reset.
module yuyv_to_rgb_converter_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  yrc_pkg::yuyv_in_t macropixel,
    output logic              done,
    output yrc_pkg::rgb_out_t rgb_pair
);
    import yrc_pkg::*;

    logic                    accept;
    logic signed [7:0]       du, dv;
    logic signed [ACC_W-1:0] du_ext, dv_ext;
    chroma_prod_t            prod_next, prod_reg;
    logic [7:0]              luma_first_reg, luma_second_reg;
    logic [STAGES-1:0]       valid_next, valid_reg;
    logic [STAGES-1:0]       frame_end_next, frame_end_reg;
    pixel_rgb_t              rgb_first, rgb_second;

    // Never holds off input
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Stage 1: chroma offsets and products; flipping the MSB subtracts 128
    assign du     = $signed({~macropixel.chroma_blue[7], macropixel.chroma_blue[6:0]});
    assign dv     = $signed({~macropixel.chroma_red[7], macropixel.chroma_red[6:0]});
    assign du_ext = ACC_W'(du);
    assign dv_ext = ACC_W'(dv);

    always_comb
    begin
        prod_next.rv = dv_ext * COEF_RV;
        prod_next.gv = dv_ext * COEF_GV;
        prod_next.gu = du_ext * COEF_GU;
        prod_next.bu = du_ext * COEF_BU;
    end

    always_ff @(posedge clk)
    begin
        prod_reg        <= prod_next;
        luma_first_reg  <= macropixel.luma_first;
        luma_second_reg <= macropixel.luma_second;
    end

    // Valid bits and frame mark travel alongside the data
    assign valid_next     = {valid_reg[STAGES-2:0], accept};
    assign frame_end_next = {frame_end_reg[STAGES-2:0], macropixel.frame_end_in};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        frame_end_reg <= frame_end_next;
    end

    // Stages 2 and 3 for each pixel
    yrc_pixel u_pixel_first (
        .clk  (clk),
        .luma (luma_first_reg),
        .prod (prod_reg),
        .rgb  (rgb_first)
    );

    yrc_pixel u_pixel_second (
        .clk  (clk),
        .luma (luma_second_reg),
        .prod (prod_reg),
        .rgb  (rgb_second)
    );

    // Result
    assign done = valid_reg[STAGES-1];

    always_comb
    begin
        rgb_pair.red_first     = rgb_first.red;
        rgb_pair.green_first   = rgb_first.green;
        rgb_pair.blue_first    = rgb_first.blue;
        rgb_pair.red_second    = rgb_second.red;
        rgb_pair.green_second  = rgb_second.green;
        rgb_pair.blue_second   = rgb_second.blue;
        rgb_pair.frame_end_out = frame_end_reg[STAGES-1];
    end

endmodule

### rtl/yrc_checker.sv
// Port-level checker for the converter, bound to the top level.
module yrc_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input yrc_pkg::yuyv_in_t macropixel,
    input logic              done,
    input yrc_pkg::rgb_out_t rgb_pair
);
    import yrc_pkg::*;

    // Every result follows a matching input transfer
    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, STAGES))
        else $error("result without a matching input transfer");

    // Every input transfer gives a result
    a_transfer_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##STAGES done)
        else $error("input transfer lost");

    // Frame mark stays aligned with its macropixel
    a_frame_mark_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rgb_pair.frame_end_out == $past(macropixel.frame_end_in, STAGES)))
        else $error("frame mark out of step with data");

    // Scaled channels never exceed 219
    a_channel_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rgb_pair.red_first <= 8'd219 && rgb_pair.green_first <= 8'd219 &&
                  rgb_pair.blue_first <= 8'd219 && rgb_pair.red_second <= 8'd219 &&
                  rgb_pair.green_second <= 8'd219 && rgb_pair.blue_second <= 8'd219))
        else $error("scaled channel out of range");

endmodule

bind yuyv_to_rgb_converter_core yrc_checker u_yrc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .macropixel (macropixel),
    .done       (done),
    .rgb_pair   (rgb_pair)
);

### test/testbench.sv
// Testbench for the YUYV 4:2:2 to scaled RGB converter core.
`timescale 1ns / 100ps

module testbench;
    import yrc_pkg::*;

    // Fixed-point coefficients, value * 65536
    localparam int RED_FROM_V   = 89831;
    localparam int GREEN_FROM_V = 45744;
    localparam int GREEN_FROM_U = 22127;
    localparam int BLUE_FROM_U  = 113538;
    localparam int CHROMA_MID   = 128;
    localparam int PIPE_DEPTH   = 3;
    localparam int RANDOM_ITEMS = 600;
    localparam int CYCLE_LIMIT  = 200000;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    yuyv_in_t  macropixel;
    logic      done;
    rgb_out_t  rgb_pair;

    yuyv_in_t  pending_q[$];
    rgb_out_t  expected_q[$];
    int        total_items;
    int        accepted_count;
    int        checked_count;
    int        frame_marks;
    int        fail_count;
    int        gap_left;
    int        cycle_count;
    bit        taken;
    bit        steady_run;

    yuyv_to_rgb_converter_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .macropixel (macropixel),
        .done       (done),
        .rgb_pair   (rgb_pair)
    );

    always #5 clk = ~clk;

    // Clamp a 16-fraction-bit sum to 0..255, then scale to 0..219
    function automatic logic [7:0] scaled_channel(int acc);
        int whole;
        if (acc < 0)
            return 8'd0;
        whole = acc >>> 16;
        if (whole > 255)
            whole = 255;
        return 8'((whole * 220) >> 8);
    endfunction

    function automatic pixel_rgb_t convert_pixel(int luma, int du, int dv);
        pixel_rgb_t px;
        int         base;
        base     = luma * 65536;
        px.red   = scaled_channel(base + RED_FROM_V * dv);
        px.green = scaled_channel(base - GREEN_FROM_V * dv - GREEN_FROM_U * du);
        px.blue  = scaled_channel(base + BLUE_FROM_U * du);
        return px;
    endfunction

    // Both pixels of a macropixel share the chroma pair
    function automatic rgb_out_t convert_macropixel(yuyv_in_t mp);
        rgb_out_t   res;
        pixel_rgb_t p0;
        pixel_rgb_t p1;
        int         du;
        int         dv;
        du = int'(mp.chroma_blue) - CHROMA_MID;
        dv = int'(mp.chroma_red) - CHROMA_MID;
        p0 = convert_pixel(int'(mp.luma_first), du, dv);
        p1 = convert_pixel(int'(mp.luma_second), du, dv);
        res.red_first     = p0.red;
        res.green_first   = p0.green;
        res.blue_first    = p0.blue;
        res.red_second    = p1.red;
        res.green_second  = p1.green;
        res.blue_second   = p1.blue;
        res.frame_end_out = mp.frame_end_in;
        return res;
    endfunction

    function automatic yuyv_in_t make_macropixel(int y0, int u, int y1, int v, bit fe);
        yuyv_in_t mp;
        mp.luma_first   = 8'(y0);
        mp.chroma_blue  = 8'(u);
        mp.luma_second  = 8'(y1);
        mp.chroma_red   = 8'(v);
        mp.frame_end_in = fe;
        return mp;
    endfunction

    // Bytes lean towards the extremes and mid-scale now and then
    function automatic int pick_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return ($urandom_range(0, 1) != 0) ? 255 : 0;
        if (r == 1)
            return $urandom_range(120, 136);
        return $urandom_range(0, 255);
    endfunction

    // Mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic void compare_field(string name, logic [7:0] exp_val,
                                          logic [7:0] act_val);
        if (exp_val !== act_val)
        begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            fail_count++;
        end
    endfunction

    // Transfer tracking and result checking at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_q.size() == 0)
            begin
                $error("result with nothing expected: %h", rgb_pair);
                fail_count++;
            end
            else
            begin
                rgb_out_t exp_pair;
                exp_pair = expected_q.pop_front();
                compare_field("red_first",     exp_pair.red_first,     rgb_pair.red_first);
                compare_field("green_first",   exp_pair.green_first,   rgb_pair.green_first);
                compare_field("blue_first",    exp_pair.blue_first,    rgb_pair.blue_first);
                compare_field("red_second",    exp_pair.red_second,    rgb_pair.red_second);
                compare_field("green_second",  exp_pair.green_second,  rgb_pair.green_second);
                compare_field("blue_second",   exp_pair.blue_second,   rgb_pair.blue_second);
                compare_field("frame_end_out", 8'(exp_pair.frame_end_out),
                              8'(rgb_pair.frame_end_out));
                checked_count++;
            end
        end
        taken = rst_n && start && !busy;
        if (taken)
        begin
            expected_q.push_back(convert_macropixel(macropixel));
            accepted_count++;
            if (macropixel.frame_end_in)
                frame_marks++;
        end
    end

    // Input driver: one macropixel from the pending queue per transfer
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (!start || taken)
        begin
            if (start)
            begin
                void'(pending_q.pop_front());
                if ($urandom_range(0, 39) == 0)
                    steady_run = !steady_run;
                gap_left = steady_run ? 0 : pick_gap();
            end
            if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (pending_q.size() > 0)
            begin
                macropixel <= pending_q[0];
                start      <= 1'b1;
            end
            else
                start <= 1'b0;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("yuyv_to_rgb_converter_core verification failed");
            $finish;
        end
    end

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        start          = 1'b0;
        macropixel     = '0;
        taken          = 1'b0;
        steady_run     = 1'b0;
        gap_left       = 0;
        accepted_count = 0;
        checked_count  = 0;
        frame_marks    = 0;
        fail_count     = 0;
        cycle_count    = 0;

        // Directed: extremes, neutral chroma, clamping and floor cases
        pending_q.push_back(make_macropixel(0, 0, 0, 0, 1'b0));
        pending_q.push_back(make_macropixel(255, 255, 255, 255, 1'b1));
        pending_q.push_back(make_macropixel(0, 128, 255, 128, 1'b0));
        pending_q.push_back(make_macropixel(1, 128, 254, 128, 1'b0));
        pending_q.push_back(make_macropixel(255, 0, 0, 0, 1'b0));
        pending_q.push_back(make_macropixel(0, 255, 255, 0, 1'b0));
        pending_q.push_back(make_macropixel(255, 0, 0, 255, 1'b1));
        pending_q.push_back(make_macropixel(128, 0, 128, 255, 1'b0));
        pending_q.push_back(make_macropixel(128, 255, 128, 0, 1'b0));
        // sum just below zero clamps to zero; small negative offsets floor
        pending_q.push_back(make_macropixel(1, 127, 10, 127, 1'b0));
        pending_q.push_back(make_macropixel(10, 129, 1, 127, 1'b0));
        // sum just past 255
        pending_q.push_back(make_macropixel(254, 129, 255, 129, 1'b0));
        pending_q.push_back(make_macropixel(250, 131, 200, 160, 1'b0));
        pending_q.push_back(make_macropixel(16, 128, 235, 128, 1'b1));
        pending_q.push_back(make_macropixel(170, 85, 85, 170, 1'b0));
        pending_q.push_back(make_macropixel(85, 170, 170, 85, 1'b1));
        pending_q.push_back(make_macropixel(100, 200, 30, 60, 1'b0));

        for (int i = 0; i < RANDOM_ITEMS; i++)
            pending_q.push_back(make_macropixel(pick_byte(), pick_byte(), pick_byte(),
                                                pick_byte(),
                                                $urandom_range(0, 15) == 0));
        total_items = pending_q.size();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (accepted_count < total_items)
            @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 5) @(posedge clk);

        $display("%0d macropixels converted, %0d results checked, %0d frame marks passed",
                 accepted_count, checked_count, frame_marks);
        $display("stimulus covered clamping at both ends, neutral chroma and random gaps");
        if (fail_count == 0)
            $display("yuyv_to_rgb_converter_core verification clean");
        else
            $display("yuyv_to_rgb_converter_core verification failed");
        $finish;
    end

endmodule
